@@ rtl/three_voice_looping_audio_mixer_unit_assert.svh @@
// Assertion macros shared by the mixer RTL.
// Each macro wraps one concurrent assertion clocked on the rising edge and
// disabled while the active-low reset is asserted.
`ifndef THREE_VOICE_LOOPING_AUDIO_MIXER_UNIT_ASSERT_SVH
`define THREE_VOICE_LOOPING_AUDIO_MIXER_UNIT_ASSERT_SVH

// The condition holds at every clock edge.
`define TVLAM_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define TVLAM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds at the edge after the antecedent.
`define TVLAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tvlam_pkg.sv @@
// Shared types and fixed constants of the three-voice looping mixer.
// No dependencies.
package tvlam_pkg;

	localparam int NUM_VOICES   = 3;
	localparam int LEN_W        = 17;
	localparam int POS_W        = 18;
	localparam int SPAN_W       = 19;
	localparam int VOL_W        = 32;
	localparam int GAIN_W       = 16;
	localparam int SMP_W        = 16;
	localparam int MAX_LOOP     = 65536;

	localparam int RAMP_SHIFT   = 24;
	localparam int TARGET_SHIFT = 15;
	localparam int OUT_SHIFT    = 45;
	localparam int RAMP_W       = 46;
	localparam int PROD_W       = 49;
	localparam int AMB_W        = 50;
	localparam int CH_W         = 33;
	localparam int CQ_W         = 66;
	localparam int TOT_W        = 67;

	// 0.00015 in Q0.24.
	localparam logic [11:0] RAMP_COEF = 12'd2517;

	localparam logic signed [RAMP_W-1:0] RAMP_ROUND = RAMP_W'((64'd1 << RAMP_SHIFT) - 64'd1);
	localparam logic signed [TOT_W-1:0]  OUT_ROUND  = TOT_W'((64'd1 << OUT_SHIFT) - 64'd1);
	localparam logic signed [TOT_W-1:0]  SAT_HI     = TOT_W'(32767);
	localparam logic signed [TOT_W-1:0]  SAT_LO     = TOT_W'(-32768);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] REG_VOICE0_LENGTH = 2'd0;
	localparam logic [1:0] REG_VOICE1_LENGTH = 2'd1;
	localparam logic [1:0] REG_VOICE2_LENGTH = 2'd2;

	localparam logic [1:0] VOICE_AMB0  = 2'd0;
	localparam logic [1:0] VOICE_AMB1  = 2'd1;
	localparam logic [1:0] CHASE_VOICE = 2'd2;
	localparam logic [1:0] VOICE_NONE  = 2'd3;

	localparam logic [1:0] LEVEL_VOICE0 = 2'd0;
	localparam logic [1:0] LEVEL_VOICE1 = 2'd1;

	typedef logic signed [SMP_W-1:0] sample_t;
	typedef logic [LEN_W-1:0]        length_t;
	typedef logic [POS_W-1:0]        position_t;
	typedef logic [VOL_W-1:0]        volume_t;
	typedef logic [GAIN_W-1:0]       gain_t;

endpackage

@@ rtl/three_voice_looping_audio_mixer_unit.sv @@
// Three-voice looping mixer: sample memory, 4x interpolation, volume ramps, stereo mixdown.
// Depends on tvlam_pkg and three_voice_looping_audio_mixer_unit_assert.svh.
// A load beat does not leave the sequencer busy. A tick beat keeps in_stall high until its frame
// is loaded to the output, which out_stall can hold off: voices 0 and 1 take five steps and the
// chase voice four on the one memory read port, then four mixdown steps follow.
// Reset clears positions and volumes and sets every loop length to 1; sample memory is not cleared.
module three_voice_looping_audio_mixer_unit #(
	parameter int VOICE_DEPTH = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [1:0]         cfg_index,
	input  tvlam_pkg::length_t cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [1:0]         voice_select,
	input  logic [15:0]        sample_address,
	input  tvlam_pkg::sample_t sample_value,
	input  logic [1:0]         level_select,
	input  tvlam_pkg::gain_t   ambient_gain,
	input  tvlam_pkg::gain_t   chase_gain,
	input  tvlam_pkg::gain_t   left_gain,
	input  tvlam_pkg::gain_t   right_gain,
	output logic               out_valid,
	input  logic               out_stall,
	output tvlam_pkg::sample_t left_sample,
	output tvlam_pkg::sample_t right_sample
);
	import tvlam_pkg::*;

	`include "three_voice_looping_audio_mixer_unit_assert.svh"

	localparam int AW        = $clog2(VOICE_DEPTH);
	localparam int MEM_DEPTH = 3 * (2 ** AW);
	localparam int CAP       = (VOICE_DEPTH < MAX_LOOP) ? VOICE_DEPTH : MAX_LOOP;
	localparam logic [LEN_W-1:0]  CAP_LEN  = LEN_W'(CAP);
	localparam logic [SPAN_W-1:0] MAX_SPAN = SPAN_W'(4 * CAP);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ADDR   = 4'd1;
	localparam logic [3:0] S_NEXT   = 4'd2;
	localparam logic [3:0] S_INTERP = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_ACC    = 4'd5;
	localparam logic [3:0] S_CH_L   = 4'd6;
	localparam logic [3:0] S_CH_R   = 4'd7;
	localparam logic [3:0] S_SUM    = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	function automatic sample_t scale_out(input logic signed [TOT_W-1:0] tot);
		logic signed [TOT_W-1:0] adj;
		logic signed [TOT_W-1:0] sh;
		adj = tot + (tot[TOT_W-1] ? OUT_ROUND : {TOT_W{1'b0}});
		sh = adj >>> OUT_SHIFT;
		if (sh > SAT_HI) begin
			scale_out = sample_t'(16'sd32767);
		end else if (sh < SAT_LO) begin
			scale_out = sample_t'(-16'sd32768);
		end else begin
			scale_out = sh[SMP_W-1:0];
		end
	endfunction

	// Control and model state.
	logic [3:0]  state_q;
	logic [1:0]  vcnt_q;
	logic        out_valid_q;
	length_t     len_q [0:NUM_VOICES-1];
	position_t   pos_q [0:NUM_VOICES-1];
	volume_t     vol_q [0:NUM_VOICES-1];

	// Sample memory.
	sample_t     mem [0:MEM_DEPTH-1];
	sample_t     rdata_q;
	logic [AW+1:0] rd_idx;
	logic [AW+1:0] wr_idx;
	logic        mem_we;

	// Per-beat and per-voice working registers.
	logic [1:0]  level_q;
	gain_t       amb_gain_q;
	gain_t       chase_gain_q;
	gain_t       lg_q;
	gain_t       rg_q;
	logic [1:0]  f_q;
	logic [15:0] nx_q;
	position_t   pos_next_q;
	logic signed [RAMP_W-1:0] ramp_prod_q;
	sample_t     a_q;
	sample_t     val_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [AMB_W-1:0]  amb_q;
	logic signed [CH_W-1:0]   pl_q;
	logic signed [CH_W-1:0]   pr_q;
	logic signed [CQ_W-1:0]   ql_q;
	logic signed [CQ_W-1:0]   qr_q;
	logic signed [TOT_W-1:0]  tot_l_q;
	logic signed [TOT_W-1:0]  tot_r_q;
	sample_t     left_q;
	sample_t     right_q;

	logic        in_fire;
	logic        out_load;

	// Address-step logic.
	length_t     len_raw;
	length_t     eff_len;
	logic [SPAN_W-1:0] span;
	position_t   pos_raw;
	position_t   pos_fix;
	logic [15:0] idx;
	logic [16:0] idx_inc;
	logic [15:0] nx;
	logic [SPAN_W-1:0] pos_inc;
	position_t   pos_next;
	volume_t     vol_cur;
	volume_t     amb_t;
	volume_t     chase_t;
	volume_t     tgt;
	logic signed [VOL_W:0]    vol_diff;
	logic signed [RAMP_W-1:0] ramp_prod;
	logic signed [RAMP_W-1:0] ramp_adj;
	logic signed [RAMP_W-1:0] ramp_step;
	volume_t     vol_new;

	// Interpolation logic.
	logic signed [16:0] diff_ab;
	logic signed [18:0] interp_term;
	logic signed [18:0] interp_sum;
	logic signed [18:0] interp_adj;
	sample_t     interp_val;

	assign in_stall     = (state_q != S_IDLE);
	assign in_fire      = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign out_load     = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		len_raw = len_q[vcnt_q];
		if (len_raw == '0) begin
			eff_len = LEN_W'(1);
		end else if (len_raw > CAP_LEN) begin
			eff_len = CAP_LEN;
		end else begin
			eff_len = len_raw;
		end
		span = {eff_len, 2'b00};
		pos_raw = pos_q[vcnt_q];
		// A length change can leave a position past the loop; restart it.
		pos_fix = ({1'b0, pos_raw} >= span) ? '0 : pos_raw;
		idx = pos_fix[POS_W-1:2];
		idx_inc = {1'b0, idx} + 17'd1;
		nx = (idx_inc == eff_len) ? 16'd0 : idx_inc[15:0];
		pos_inc = {1'b0, pos_fix} + SPAN_W'(1);
		pos_next = (pos_inc == span) ? '0 : pos_inc[POS_W-1:0];

		vol_cur = vol_q[vcnt_q];
		amb_t = {1'b0, amb_gain_q, 15'd0};
		chase_t = {1'b0, chase_gain_q, 15'd0};
		if (vcnt_q == CHASE_VOICE) begin
			tgt = chase_t;
		end else if ((vcnt_q == VOICE_AMB0 && level_q == LEVEL_VOICE0) ||
				(vcnt_q == VOICE_AMB1 && level_q == LEVEL_VOICE1)) begin
			tgt = amb_t;
		end else begin
			tgt = '0;
		end
		vol_diff = $signed({1'b0, tgt}) - $signed({1'b0, vol_cur});
		ramp_prod = vol_diff * $signed({1'b0, RAMP_COEF});

		// The step truncates toward zero.
		ramp_adj = ramp_prod_q + (ramp_prod_q[RAMP_W-1] ? RAMP_ROUND : {RAMP_W{1'b0}});
		ramp_step = ramp_adj >>> RAMP_SHIFT;
		vol_new = vol_cur + ramp_step[VOL_W-1:0];
	end

	always_comb begin
		diff_ab = $signed({rdata_q[SMP_W-1], rdata_q}) - $signed({a_q[SMP_W-1], a_q});
		// a*(4-f) + b*f is written as 4a + (b-a)*f.
		interp_term = (f_q[1] ? (19'(diff_ab) <<< 1) : 19'sd0) + (f_q[0] ? 19'(diff_ab) : 19'sd0);
		interp_sum = $signed({a_q[SMP_W-1], a_q, 2'b00}) + interp_term;
		interp_adj = interp_sum + (interp_sum[18] ? 19'sd3 : 19'sd0);
		interp_val = interp_adj[17:2];
	end

	assign mem_we = in_fire && (command == CMD_LOAD) && (voice_select != VOICE_NONE) &&
		({16'd0, sample_address} < 32'(VOICE_DEPTH));
	assign wr_idx = {voice_select, AW'(sample_address)};
	assign rd_idx = (state_q == S_NEXT) ? {vcnt_q, AW'(nx_q)} : {vcnt_q, AW'(idx)};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= sample_value;
		end
		rdata_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int v = 0; v < NUM_VOICES; v++) begin
				len_q[v] <= LEN_W'(1);
				pos_q[v] <= '0;
				vol_q[v] <= '0;
			end
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_VOICE0_LENGTH: len_q[0] <= cfg_data;
					REG_VOICE1_LENGTH: len_q[1] <= cfg_data;
					REG_VOICE2_LENGTH: len_q[2] <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire && command == CMD_TICK) begin
						vcnt_q <= '0;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: state_q <= S_NEXT;
				S_NEXT: begin
					pos_q[vcnt_q] <= pos_next_q;
					vol_q[vcnt_q] <= vol_new;
					state_q <= S_INTERP;
				end
				S_INTERP: state_q <= S_MUL;
				S_MUL: state_q <= (vcnt_q == CHASE_VOICE) ? S_CH_L : S_ACC;
				S_ACC: begin
					vcnt_q <= vcnt_q + 2'd1;
					state_q <= S_ADDR;
				end
				S_CH_L: state_q <= S_CH_R;
				S_CH_R: state_q <= S_SUM;
				S_SUM: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && command == CMD_TICK) begin
			level_q <= level_select;
			amb_gain_q <= ambient_gain;
			chase_gain_q <= chase_gain;
			lg_q <= left_gain;
			rg_q <= right_gain;
			amb_q <= '0;
		end
		if (state_q == S_ADDR) begin
			f_q <= pos_fix[1:0];
			nx_q <= nx;
			pos_next_q <= pos_next;
			ramp_prod_q <= ramp_prod;
		end
		if (state_q == S_NEXT) begin
			a_q <= rdata_q;
		end
		if (state_q == S_INTERP) begin
			val_q <= interp_val;
		end
		if (state_q == S_MUL) begin
			// The chase voice folds its channel gain in before the volume.
			if (vcnt_q == CHASE_VOICE) begin
				pl_q <= val_q * $signed({1'b0, lg_q});
				pr_q <= val_q * $signed({1'b0, rg_q});
			end else begin
				prod_q <= val_q * $signed({1'b0, vol_cur});
			end
		end
		if (state_q == S_ACC) begin
			amb_q <= amb_q + AMB_W'(prod_q);
		end
		if (state_q == S_CH_L) begin
			ql_q <= pl_q * $signed({1'b0, vol_q[CHASE_VOICE]});
		end
		if (state_q == S_CH_R) begin
			qr_q <= pr_q * $signed({1'b0, vol_q[CHASE_VOICE]});
		end
		if (state_q == S_SUM) begin
			tot_l_q <= (TOT_W'(amb_q) <<< TARGET_SHIFT) + TOT_W'(ql_q);
			tot_r_q <= (TOT_W'(amb_q) <<< TARGET_SHIFT) + TOT_W'(qr_q);
		end
		if (out_load) begin
			left_q <= scale_out(tot_l_q);
			right_q <= scale_out(tot_r_q);
		end
	end

	`TVLAM_ASSERT_IMP(a_chase_last, clk, arst_n, state_q == S_CH_L, vcnt_q == CHASE_VOICE, "mixdown started before the chase voice")
	`TVLAM_ASSERT_HOLDS(a_pos_bound, clk, arst_n, ({1'b0, pos_q[0]} < MAX_SPAN) && ({1'b0, pos_q[1]} < MAX_SPAN) && ({1'b0, pos_q[2]} < MAX_SPAN), "play position beyond the largest loop")
	`TVLAM_ASSERT_HOLDS(a_vol_bound, clk, arst_n, !vol_q[0][VOL_W-1] && !vol_q[1][VOL_W-1] && !vol_q[2][VOL_W-1], "volume ramp overshot its target range")
	`TVLAM_ASSERT_NEXT(a_load_one_cycle, clk, arst_n, in_fire && command == CMD_LOAD, state_q == S_IDLE, "load beat left the sequencer busy")
	`TVLAM_ASSERT_NEXT(a_frame_out, clk, arst_n, out_load, out_valid_q && state_q == S_IDLE, "finished frame not presented")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for three_voice_looping_audio_mixer_unit: load and tick beats go in,
// stereo frames come out and are compared with a cycle-free model of the mixer kept here.
// Depends on tvlam_pkg and the mixer RTL.
module tb_top;
	import tvlam_pkg::*;

	localparam int DEPTH = 65536;
	localparam int LOOP_CAP = (DEPTH < MAX_LOOP) ? DEPTH : MAX_LOOP;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLDOFF_CYCLES = 400;
	localparam longint RAMP_MUL = 2517;
	localparam longint OUT_MAX = 32767;
	localparam longint OUT_MIN = -32768;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [1:0] LEVEL_MUTE = 2'd2;
	localparam logic [1:0] LEVEL_MUTE_ALT = 2'd3;

	typedef struct {
		logic       command;
		logic [1:0] voice;
		logic [15:0] addr;
		sample_t    value;
		logic [1:0] level;
		gain_t      amb;
		gain_t      chase;
		gain_t      left;
		gain_t      right;
	} beat_t;

	typedef struct {
		sample_t left;
		sample_t right;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [1:0]  cfg_index = REG_VOICE0_LENGTH;
	length_t     cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = CMD_LOAD;
	logic [1:0]  voice_select = VOICE_AMB0;
	logic [15:0] sample_address = '0;
	sample_t     sample_value = '0;
	logic [1:0]  level_select = LEVEL_VOICE0;
	gain_t       ambient_gain = '0;
	gain_t       chase_gain = '0;
	gain_t       left_gain = '0;
	gain_t       right_gain = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	sample_t     left_sample;
	sample_t     right_sample;

	int send_idle_pct = 12;
	int recv_idle_pct = 74;
	int holdoff_requests = 0;
	int holdoff_served = 0;
	int holdoff_left = 0;
	int error_count = 0;
	int beats_sent = 0;
	int ticks_sent = 0;
	int loads_sent = 0;
	int frames_checked = 0;
	int reg_writes = 0;

	// Mixer model state.
	sample_t         voice_mem [NUM_VOICES][DEPTH];
	bit              loaded [NUM_VOICES][DEPTH];
	logic [POS_W-1:0] play_pos [NUM_VOICES] = '{default: '0};
	logic [VOL_W-1:0] volume [NUM_VOICES] = '{default: '0};
	length_t         loop_len [NUM_VOICES] = '{default: 17'd1};
	frame_t          expected_frames [$];

	three_voice_looping_audio_mixer_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.voice_select   (voice_select),
		.sample_address (sample_address),
		.sample_value   (sample_value),
		.level_select   (level_select),
		.ambient_gain   (ambient_gain),
		.chase_gain     (chase_gain),
		.left_gain      (left_gain),
		.right_gain     (right_gain),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.left_sample    (left_sample),
		.right_sample   (right_sample)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("tb_top: errors");
		$finish;
	end

	function automatic int active_len(int v);
		int n;
		n = loop_len[v];
		if (n < 1) n = 1;
		if (n > LOOP_CAP) n = LOOP_CAP;
		return n;
	endfunction

	// A position left beyond the loop by a shorter length restarts at zero.
	function automatic int read_pos(int v);
		int p;
		p = play_pos[v];
		if (p >= 4 * active_len(v)) p = 0;
		return p;
	endfunction

	function automatic longint shift_toward_zero(longint x, int sh);
		if (x >= 0) return x >>> sh;
		return -((-x) >>> sh);
	endfunction

	function automatic sample_t saturate_sample(longint x);
		if (x > OUT_MAX) return sample_t'(OUT_MAX);
		if (x < OUT_MIN) return sample_t'(OUT_MIN);
		return sample_t'(x);
	endfunction

	function automatic frame_t mix_frame(beat_t b);
		logic [VOL_W-1:0] target [NUM_VOICES];
		longint ambient, chase, step;
		int n, p, i, nx, f, s;
		frame_t fr;
		target[0] = (b.level == LEVEL_VOICE0) ? (VOL_W'(b.amb) << 15) : '0;
		target[1] = (b.level == LEVEL_VOICE1) ? (VOL_W'(b.amb) << 15) : '0;
		target[2] = VOL_W'(b.chase) << 15;
		ambient = 0;
		chase = 0;
		for (int v = 0; v < NUM_VOICES; v++) begin
			// The volume ramp is applied before the voice is sampled.
			step = shift_toward_zero((longint'(target[v]) - longint'(volume[v])) * RAMP_MUL, 24);
			volume[v] = VOL_W'(longint'(volume[v]) + step);
			n = active_len(v);
			p = read_pos(v);
			i = p >> 2;
			nx = (i + 1) % n;
			f = p & 3;
			s = (int'(voice_mem[v][i]) * (4 - f) + int'(voice_mem[v][nx]) * f) / 4;
			play_pos[v] = POS_W'((p + 1) % (4 * n));
			if (v == CHASE_VOICE)
				chase = longint'(s) * longint'(volume[v]);
			else
				ambient += longint'(s) * longint'(volume[v]);
		end
		fr.left = saturate_sample(shift_toward_zero(ambient * 32768 + chase * longint'(b.left), 45));
		fr.right = saturate_sample(shift_toward_zero(ambient * 32768 + chase * longint'(b.right), 45));
		return fr;
	endfunction

	function automatic void apply_beat(beat_t b);
		beats_sent++;
		if (b.command == CMD_TICK) begin
			ticks_sent++;
			expected_frames.push_back(mix_frame(b));
		end else begin
			loads_sent++;
			if (b.voice != VOICE_NONE && int'(b.addr) < DEPTH) begin
				voice_mem[b.voice][b.addr] = b.value;
				loaded[b.voice][b.addr] = 1'b1;
			end
		end
	endfunction

	function automatic beat_t scrambled_beat();
		beat_t b;
		b.command = 1'($urandom);
		b.voice = 2'($urandom);
		b.addr = 16'($urandom);
		b.value = sample_t'($urandom);
		b.level = 2'($urandom);
		b.amb = gain_t'($urandom);
		b.chase = gain_t'($urandom);
		b.left = gain_t'($urandom);
		b.right = gain_t'($urandom);
		return b;
	endfunction

	function automatic beat_t make_load(logic [1:0] voice, logic [15:0] addr, sample_t value);
		beat_t b;
		b = scrambled_beat();
		b.command = CMD_LOAD;
		b.voice = voice;
		b.addr = addr;
		b.value = value;
		return b;
	endfunction

	function automatic beat_t make_tick(logic [1:0] level, gain_t amb, gain_t chase, gain_t left,
			gain_t right);
		beat_t b;
		b = scrambled_beat();
		b.command = CMD_TICK;
		b.level = level;
		b.amb = amb;
		b.chase = chase;
		b.left = left;
		b.right = right;
		return b;
	endfunction

	function automatic gain_t pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return gain_t'($urandom);
		endcase
	endfunction

	function automatic length_t pick_length();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return 17'd65536;
			2: return 17'h1FFFF;
			3: return length_t'($urandom);
			default: return length_t'($urandom_range(1, 24));
		endcase
	endfunction

	task automatic send_beat(beat_t b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		command <= b.command;
		voice_select <= b.voice;
		sample_address <= b.addr;
		sample_value <= b.value;
		level_select <= b.level;
		ambient_gain <= b.amb;
		chase_gain <= b.chase;
		left_gain <= b.left;
		right_gain <= b.right;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		apply_beat(b);
	endtask

	// Words a tick is about to read are loaded first, so no unwritten word is ever read.
	task automatic send_tick(beat_t b);
		int n, i, nx;
		for (int v = 0; v < NUM_VOICES; v++) begin
			n = active_len(v);
			i = read_pos(v) >> 2;
			nx = (i + 1) % n;
			if (!loaded[v][i]) send_beat(make_load(2'(v), 16'(i), sample_t'($urandom)));
			if (!loaded[v][nx]) send_beat(make_load(2'(v), 16'(nx), sample_t'($urandom)));
		end
		send_beat(b);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_for_drain();
		end_burst();
		while (expected_frames.size() != 0) @(posedge clk);
		// A load may still be in flight after the last frame.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(logic [1:0] idx, length_t val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		if (idx != REG_UNUSED) loop_len[idx] = val;
		reg_writes++;
	endtask

	task automatic set_lengths(length_t len0, length_t len1, length_t len2);
		wait_for_drain();
		write_length(REG_VOICE0_LENGTH, len0);
		write_length(REG_VOICE1_LENGTH, len1);
		write_length(REG_VOICE2_LENGTH, len2);
	endtask

	// One-word loops at reset length, full-scale words, every level and the gain extremes.
	task automatic test_single_word_loops();
		send_beat(make_load(VOICE_AMB0, 16'd0, 16'sh7FFF));
		send_beat(make_load(VOICE_AMB1, 16'd0, 16'sh8000));
		send_beat(make_load(CHASE_VOICE, 16'd0, 16'sh8000));
		send_beat(make_load(CHASE_VOICE, 16'hFFFF, 16'sh5A5A));
		send_beat(make_load(VOICE_NONE, 16'd0, 16'sh1234));
		send_tick(make_tick(LEVEL_VOICE0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_tick(make_tick(LEVEL_VOICE1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0));
		send_tick(make_tick(LEVEL_MUTE, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_tick(make_tick(LEVEL_MUTE_ALT, 16'd0, 16'd0, 16'd0, 16'd0));
		send_tick(make_tick(LEVEL_VOICE0, 16'h8000, 16'hFFFF, 16'd0, 16'hFFFF));
	endtask

	// Zero and oversized lengths, the unused register index, and positions left stale by a
	// shorter loop.
	task automatic test_length_limits();
		set_lengths('0, 17'd65536, 17'h1FFFF);
		write_length(REG_UNUSED, 17'd5);
		send_tick(make_tick(LEVEL_VOICE1, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h8000));
		send_tick(make_tick(LEVEL_VOICE0, 16'hFFFF, 16'hFFFF, 16'h4000, 16'hFFFF));
		set_lengths(17'd3, 17'd5, 17'd7);
		repeat (4) send_tick(make_tick(LEVEL_VOICE0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		set_lengths(17'd1, 17'd1, 17'd1);
		send_tick(make_tick(LEVEL_VOICE1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_tick(make_tick(LEVEL_MUTE, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0));
	endtask

	task automatic send_random_tick();
		send_tick(make_tick(2'($urandom), pick_gain(), pick_gain(), pick_gain(), pick_gain()));
	endtask

	// Mostly ticks and loads into the live loops, with stray loads, ignored loads and
	// length changes mixed in.
	task automatic test_random_traffic(int count);
		int r;
		int v;
		for (int k = 0; k < count; k++) begin
			if (k % 160 == 159) set_lengths(pick_length(), pick_length(), pick_length());
			r = $urandom_range(0, 99);
			v = $urandom_range(0, NUM_VOICES - 1);
			if (r < 65)
				send_random_tick();
			else if (r < 88)
				send_beat(make_load(2'(v), 16'($urandom_range(0, active_len(v) - 1)),
					sample_t'($urandom)));
			else if (r < 95)
				send_beat(make_load(2'(v), 16'($urandom), sample_t'($urandom)));
			else
				send_beat(make_load(VOICE_NONE, 16'($urandom), sample_t'($urandom)));
		end
	endtask

	// The receiver holds off while ticks keep coming, so the block has to stall its input.
	task automatic test_output_holdoff();
		int saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		holdoff_requests++;
		repeat (40) send_random_tick();
		send_idle_pct = saved_pct;
		wait_for_drain();
	endtask

	always @(negedge clk) begin
		if (holdoff_served != holdoff_requests) begin
			holdoff_served = holdoff_requests;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				$display("%0t: frame with none expected: left %0d, right %0d", $time,
					left_sample, right_sample);
				error_count++;
			end else begin
				want = expected_frames.pop_front();
				frames_checked++;
				if (left_sample !== want.left) begin
					$display("%0t: left_sample expected %0d, got %0d", $time, want.left,
						left_sample);
					error_count++;
				end
				if (right_sample !== want.right) begin
					$display("%0t: right_sample expected %0d, got %0d", $time, want.right,
						right_sample);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 74;
		test_single_word_loops();
		test_length_limits();
		test_random_traffic(470);

		send_idle_pct = 74;
		recv_idle_pct = 12;
		test_output_holdoff();
		test_random_traffic(470);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(470);
		wait_for_drain();

		$display("tb_top: %0d beats (%0d ticks, %0d loads), %0d frames checked, %0d register writes",
			beats_sent, ticks_sent, loads_sent, frames_checked, reg_writes);
		$display("tb_top: loop lengths 0 to 131071, three idle patterns, one %0d-cycle output hold-off",
			HOLDOFF_CYCLES);
		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
